// File: rtl/core/fixed_radius_neighbor_search_macros.svh
// Assertion macros for the port-level checker of the neighbor search block.
// Each macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef FIXED_RADIUS_NEIGHBOR_SEARCH_MACROS_SVH
`define FIXED_RADIUS_NEIGHBOR_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FRNS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("frns assertion failed");

// Next-cycle implication, disabled while in reset.
`define FRNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("frns assertion failed");

`endif

// File: rtl/core/frns_pkg.sv
// Shared types and constants of the fixed-radius neighbor search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package frns_pkg;

    localparam int MAX_AGENTS    = 8;
    localparam int AGENT_IDX_W   = $clog2(MAX_AGENTS);
    localparam int COUNT_W       = 4;
    localparam int COORD_W       = 24;
    localparam int RADIUS_W      = 24;
    localparam int SQ_W          = 2 * COORD_W;
    localparam int SUM_W         = SQ_W + 2;
    localparam int R2_W          = 2 * RADIUS_W;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 24;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_AGENTS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AGENT_COUNT     = 1'b0,
        REG_NEIGHBOR_RADIUS = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        MODE_UPDATE = 1'b0,
        MODE_TICK   = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_pos;

    typedef struct packed {
        t_mode                     mode;
        logic [AGENT_IDX_W-1:0]    agent_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [AGENT_IDX_W-1:0]    owner_index;
        logic [AGENT_IDX_W-1:0]    neighbor_index;
        logic signed [COORD_W-1:0] neighbor_x;
        logic signed [COORD_W-1:0] neighbor_y;
        logic signed [COORD_W-1:0] neighbor_z;
        logic                      last_of_owner;
        logic                      last_of_round;
    } t_out_item;

    typedef struct packed {
        logic                   valid;
        logic [AGENT_IDX_W-1:0] owner;
        logic [AGENT_IDX_W-1:0] nbr;
    } t_pair;

    typedef struct packed {
        logic                   valid;
        logic [AGENT_IDX_W-1:0] owner;
        logic [AGENT_IDX_W-1:0] nbr;
        t_pos                   pos;
    } t_hit;

    typedef struct packed {
        logic out_free;
        logic pend_valid;
    } t_stage_status;

endpackage

// File: rtl/core/frns_pos_ram.sv
// Position memory: one write port, two registered read ports.
// Depends on frns_pkg.
`timescale 1ns / 1ps

module frns_pos_ram
    import frns_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AGENT_IDX_W-1:0] i_waddr,
    input  t_pos                   i_wdata,
    input  logic                   i_re,
    input  logic [AGENT_IDX_W-1:0] i_raddr_a,
    input  logic [AGENT_IDX_W-1:0] i_raddr_b,
    output t_pos                   o_rdata_a,
    output t_pos                   o_rdata_b
);

    t_pos r_mem [MAX_AGENTS];
    t_pos r_rd_a;
    t_pos r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// File: rtl/core/frns_dist_pipe.sv
// Squared-distance pipeline: abs diff, square, sum and radius compare.
// Depends on frns_pkg; fed by frns_pos_ram read data.
`timescale 1ns / 1ps

module frns_dist_pipe
    import frns_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  t_pair           i_pair,
    input  t_pos            i_pos_a,
    input  t_pos            i_pos_b,
    input  logic [R2_W-1:0] i_r2,
    output t_hit            o_hit,
    output logic            o_busy
);

    t_pair              r_s1;
    t_pair              r_s2;
    t_pair              r_s3;
    t_hit               r_s4;
    logic [COORD_W-1:0] r_s2_mag [3];
    t_pos               r_s2_pos;
    logic [SQ_W-1:0]    r_s3_sq [3];
    t_pos               r_s3_pos;

    logic [COORD_W-1:0] mag [3];
    logic [SUM_W-1:0]   sum;
    logic               in_range;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (COORD_W + 1)'(-d) : d;
        return m[COORD_W-1:0];
    endfunction

    always_comb begin
        mag[0]   = abs_diff(i_pos_a.x, i_pos_b.x);
        mag[1]   = abs_diff(i_pos_a.y, i_pos_b.y);
        mag[2]   = abs_diff(i_pos_a.z, i_pos_b.z);
        sum      = SUM_W'(r_s3_sq[0]) + SUM_W'(r_s3_sq[1]) + SUM_W'(r_s3_sq[2]);
        in_range = (sum != '0) && (sum <= SUM_W'(i_r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else if (i_adv) begin
            r_s1 <= i_pair;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= '{valid: r_s3.valid && in_range, owner: r_s3.owner,
                      nbr: r_s3.nbr, pos: r_s3_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_mag <= mag;
            r_s2_pos <= i_pos_b;
            for (int k = 0; k < 3; k++) begin
                r_s3_sq[k] <= SQ_W'(r_s2_mag[k]) * SQ_W'(r_s2_mag[k]);
            end
            r_s3_pos <= r_s2_pos;
        end
    end

    assign o_hit  = r_s4;
    assign o_busy = r_s1.valid | r_s2.valid | r_s3.valid | r_s4.valid;

endmodule

// File: rtl/core/frns_out_stage.sv
// Result staging: holds one hit back to mark last-of-owner and last-of-round,
// and an output register toward the consumer. Depends on frns_pkg.
`timescale 1ns / 1ps

module frns_out_stage
    import frns_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  t_hit          i_hit,
    input  logic          i_flush,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output t_out_item     o_out_data,
    output t_stage_status o_status
);

    t_hit      r_pend;
    logic      r_pend_valid;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            priority if (i_adv && i_hit.valid) begin
                r_pend_valid <= 1'b1;
                r_out_valid  <= r_pend_valid || (r_out_valid && !i_out_ready);
            end else if (i_flush && r_pend_valid && out_free) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    // A new hit releases the held one; its owner decides last-of-owner.
    always_ff @(posedge i_clk) begin
        priority if (i_adv && i_hit.valid) begin
            r_pend <= i_hit;
            if (r_pend_valid) begin
                r_out <= '{owner_index: r_pend.owner, neighbor_index: r_pend.nbr,
                           neighbor_x: r_pend.pos.x, neighbor_y: r_pend.pos.y,
                           neighbor_z: r_pend.pos.z,
                           last_of_owner: (r_pend.owner != i_hit.owner),
                           last_of_round: 1'b0};
            end
        end else if (i_flush && r_pend_valid && out_free) begin
            r_out <= '{owner_index: r_pend.owner, neighbor_index: r_pend.nbr,
                       neighbor_x: r_pend.pos.x, neighbor_y: r_pend.pos.y,
                       neighbor_z: r_pend.pos.z,
                       last_of_owner: 1'b1, last_of_round: 1'b1};
        end else begin
            r_out <= r_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_status    = '{out_free: out_free, pend_valid: r_pend_valid};

endmodule

// File: rtl/core/fixed_radius_neighbor_search.sv
// Position update: written straight into the position memory.
// Tick that acts: with at least two active agents, walks n*n owner/neighbor pairs at
// one pair per cycle while the output is not stalled, through the two read ports of
// the memory and a four-stage distance pipeline; no next item is taken until it drains.
// Reset: agent count 8, radius 0, all received flags clear, no result pending.
`timescale 1ns / 1ps

module fixed_radius_neighbor_search
    import frns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                 r_state;
    t_state                 n_state;
    logic [COUNT_W-1:0]     r_agent_count;
    logic [R2_W-1:0]        r_r2;
    logic [MAX_AGENTS-1:0]  r_flags;
    logic [AGENT_IDX_W-1:0] r_i;
    logic [AGENT_IDX_W-1:0] r_j;

    logic [COUNT_W-1:0]     n_act;
    logic [COUNT_W-1:0]     last_full;
    logic [AGENT_IDX_W-1:0] last_idx;
    logic                   all_set;
    logic                   in_xfer;
    logic                   upd_ok;
    logic                   tick_acts;
    logic                   adv;
    logic                   flush;
    logic                   pipe_busy;
    t_pair                  issue;
    t_pos                   rd_a;
    t_pos                   rd_b;
    t_pos                   wr_pos;
    t_hit                   hit;
    t_stage_status          stage_st;

    always_comb begin
        n_act     = (r_agent_count > COUNT_RESET) ? COUNT_RESET : r_agent_count;
        last_full = n_act - COUNT_W'(1);
        last_idx  = last_full[AGENT_IDX_W-1:0];
        all_set   = 1'b1;
        for (int k = 0; k < MAX_AGENTS; k++) begin
            if ((COUNT_W'(k) < n_act) && !r_flags[k]) begin
                all_set = 1'b0;
            end
        end
        in_xfer   = i_in_valid && o_in_ready;
        upd_ok    = in_xfer && (i_in_data.mode == MODE_UPDATE)
                    && (COUNT_W'(i_in_data.agent_index) < n_act);
        tick_acts = in_xfer && (i_in_data.mode == MODE_TICK) && all_set;
        adv       = stage_st.out_free;
        wr_pos    = '{x: i_in_data.pos_x, y: i_in_data.pos_y, z: i_in_data.pos_z};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_acts && (n_act >= COUNT_W'(2))) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (adv && (r_i == last_idx) && (r_j == last_idx)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy && !stage_st.pend_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        issue       = '{valid: 1'b0, owner: r_i, nbr: r_j};
        flush       = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_ready  = 1'b1;
            ST_WALK:  issue.valid = 1'b1;
            ST_DRAIN: flush       = !pipe_busy;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_agent_count <= COUNT_RESET;
            r_r2          <= '0;
            r_flags       <= '0;
            r_i           <= '0;
            r_j           <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_AGENT_COUNT:     r_agent_count <= i_cfg_data[COUNT_W-1:0];
                    REG_NEIGHBOR_RADIUS: r_r2 <= R2_W'(i_cfg_data[RADIUS_W-1:0])
                                               * R2_W'(i_cfg_data[RADIUS_W-1:0]);
                    default:             r_r2 <= r_r2;
                endcase
            end
            if (upd_ok) begin
                r_flags[i_in_data.agent_index] <= 1'b1;
            end
            if (tick_acts) begin
                r_flags <= '0;
                r_i     <= '0;
                r_j     <= '0;
            end else if ((r_state == ST_WALK) && adv) begin
                if (r_j == last_idx) begin
                    r_j <= '0;
                    r_i <= r_i + AGENT_IDX_W'(1);
                end else begin
                    r_j <= r_j + AGENT_IDX_W'(1);
                end
            end
        end
    end

    // Writes happen only in idle; the memory also reads whenever the pipeline advances,
    // but only reads during a walk are used, so none of them meets a write. A searched slot
    // always reported since the last reset, so the memory needs no clearing.
    frns_pos_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (upd_ok),
        .i_waddr   (i_in_data.agent_index),
        .i_wdata   (wr_pos),
        .i_re      (adv),
        .i_raddr_a (issue.owner),
        .i_raddr_b (issue.nbr),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    frns_dist_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_pair  (issue),
        .i_pos_a (rd_a),
        .i_pos_b (rd_b),
        .i_r2    (r_r2),
        .o_hit   (hit),
        .o_busy  (pipe_busy)
    );

    frns_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_hit       (hit),
        .i_flush     (flush),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (stage_st)
    );

endmodule

// File: rtl/core/frns_checker.sv
// Port-level checker for the neighbor search block, bound to the top level.
// Depends on frns_pkg and fixed_radius_neighbor_search_macros.svh.
`timescale 1ns / 1ps
`include "fixed_radius_neighbor_search_macros.svh"

module frns_assert_checker
    import frns_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic out_stall;
    logic round_end;
    logic self_pair;
    logic upd_xfer;

    assign out_stall = o_out_valid && !i_out_ready;
    assign round_end = o_out_valid && o_out_data.last_of_round;
    assign self_pair = (o_out_data.owner_index == o_out_data.neighbor_index);
    assign upd_xfer  = i_in_valid && o_in_ready && (i_in_data.mode == MODE_UPDATE);

    // Hold a stalled result.
    `FRNS_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data))
    // The end of a round always closes the owner's list too.
    `FRNS_ASSERT_NOW(a_round_ends_owner, round_end, o_out_data.last_of_owner)
    // An agent is never listed as its own neighbor.
    `FRNS_ASSERT_NOW(a_no_self, o_out_valid, !self_pair)
    // A position update starts no results.
    `FRNS_ASSERT_NEXT(a_update_silent, upd_xfer && !o_out_valid, !o_out_valid)

endmodule

bind fixed_radius_neighbor_search frns_assert_checker u_frns_checker (.*);

// File: tb/frns_checker.sv
`timescale 1ns / 1ps
// Neighbor list checker for the fixed-radius search block: tracks register writes,
// position updates and ticks, rebuilds each round's lists and compares output transfers.
// Depends on frns_pkg only.

module frns_checker
    import frns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    logic [COUNT_W-1:0]    agent_count;
    logic [RADIUS_W-1:0]   radius;
    t_pos                  position_table [MAX_AGENTS];
    logic [MAX_AGENTS-1:0] reported;
    t_out_item             neighbor_q [$];

    function automatic int active_agents();
        return (agent_count > MAX_AGENTS) ? MAX_AGENTS : int'(agent_count);
    endfunction

    function automatic logic [63:0] axis_sq(input logic signed [COORD_W-1:0] a,
                                            input logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return 64'(d * d);
    endfunction

    function automatic string describe(input t_out_item e);
        return $sformatf("owner %0d nbr %0d pos (%0d, %0d, %0d) last_owner %b last_round %b",
                         e.owner_index, e.neighbor_index, e.neighbor_x, e.neighbor_y,
                         e.neighbor_z, e.last_of_owner, e.last_of_round);
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Walk owners and neighbors by index and queue every in-range pair at nonzero distance.
    task automatic search_round();
        int          n, i, j, k, first;
        logic [63:0] r2, d2;
        t_out_item   found [MAX_AGENTS*MAX_AGENTS];
        n = active_agents();
        for (i = 0; i < n; i++)
            if (!reported[i])
                return;
        reported = '0;
        r2 = 64'(radius) * 64'(radius);
        k = 0;
        for (i = 0; i < n; i++) begin
            first = k;
            for (j = 0; j < n; j++) begin
                d2 = axis_sq(position_table[i].x, position_table[j].x)
                   + axis_sq(position_table[i].y, position_table[j].y)
                   + axis_sq(position_table[i].z, position_table[j].z);
                if (d2 != 0 && d2 <= r2) begin
                    found[k].owner_index    = AGENT_IDX_W'(i);
                    found[k].neighbor_index = AGENT_IDX_W'(j);
                    found[k].neighbor_x     = position_table[j].x;
                    found[k].neighbor_y     = position_table[j].y;
                    found[k].neighbor_z     = position_table[j].z;
                    found[k].last_of_owner  = 1'b0;
                    found[k].last_of_round  = 1'b0;
                    k++;
                end
            end
            if (k > first)
                found[k-1].last_of_owner = 1'b1;
        end
        if (k > 0)
            found[k-1].last_of_round = 1'b1;
        for (i = 0; i < k; i++)
            neighbor_q.push_back(found[i]);
    endtask

    task automatic take_item(input t_in_item item);
        if (item.mode == MODE_UPDATE) begin
            // drop updates for slots outside the active set
            if (int'(item.agent_index) < active_agents()) begin
                position_table[item.agent_index].x = item.pos_x;
                position_table[item.agent_index].y = item.pos_y;
                position_table[item.agent_index].z = item.pos_z;
                reported[item.agent_index] = 1'b1;
            end
        end else begin
            search_round();
        end
    endtask

    task automatic check_entry(input t_out_item got);
        t_out_item want;
        if (neighbor_q.size() == 0) begin
            note_failure({"unexpected entry: ", describe(got)});
            return;
        end
        want = neighbor_q.pop_front();
        o_checked++;
        if (got.owner_index !== want.owner_index || got.neighbor_index !== want.neighbor_index
                || got.neighbor_x !== want.neighbor_x || got.neighbor_y !== want.neighbor_y
                || got.neighbor_z !== want.neighbor_z
                || got.last_of_owner !== want.last_of_owner
                || got.last_of_round !== want.last_of_round)
            note_failure({"mismatch: expected ", describe(want), " got ", describe(got)});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            agent_count = COUNT_RESET;
            radius      = '0;
            reported    = '0;
            for (int s = 0; s < MAX_AGENTS; s++)
                position_table[s] = '0;
            neighbor_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_entry(i_out_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_AGENT_COUNT:     agent_count = i_cfg_data[COUNT_W-1:0];
                    REG_NEIGHBOR_RADIUS: radius      = i_cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_item(i_in_data);
        end
        o_pending = neighbor_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the neighbor search testbench: clock, reset, register setup, update/tick
// stimulus and output back-pressure; checking lives in frns_checker. Uses frns_pkg.

module tb_top;
    import frns_pkg::*;

    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 100;
    localparam int LIMIT_NS      = 10_000_000;

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_reg              cfg_idx   = REG_AGENT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  hold_rx   = 1'b0;
    logic                  pressure_go = 1'b0;

    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    int fail_count, pending, checked;
    int sent_count, tick_count, setting_count;
    int tx_quiet, rx_quiet, rx_wait, rx_gap;

    always #4 i_clk = ~i_clk;

    fixed_radius_neighbor_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    frns_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Mostly a random idle gap, with occasional runs of back-to-back transfers.
    function automatic int draw_gap(inout int quiet_run);
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_run = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    always @(posedge i_clk) begin
        if (!rst_n || hold_rx) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else if (out_valid && out_ready) begin
            rx_gap = draw_gap(rx_quiet);
            out_ready <= (rx_gap == 0);
            rx_wait   <= rx_gap;
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            out_ready <= 1'b1;
            rx_wait   <= 0;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic t_pos random_pos();
        t_pos p;
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.z = COORD_W'($urandom);
        return p;
    endfunction

    function automatic t_pos near_pos(input t_pos center, input int spread);
        t_pos p;
        p.x = center.x + COORD_W'($urandom_range(0, 2 * spread)) - COORD_W'(spread);
        p.y = center.y + COORD_W'($urandom_range(0, 2 * spread)) - COORD_W'(spread);
        p.z = center.z + COORD_W'($urandom_range(0, 2 * spread)) - COORD_W'(spread);
        return p;
    endfunction

    function automatic t_in_item update_item(input logic [AGENT_IDX_W-1:0] idx,
                                             input t_pos p);
        t_in_item item;
        item.mode        = MODE_UPDATE;
        item.agent_index = idx;
        item.pos_x       = p.x;
        item.pos_y       = p.y;
        item.pos_z       = p.z;
        return item;
    endfunction

    // Ticks carry random content in the ignored fields.
    function automatic t_in_item tick_item();
        t_in_item item;
        item = update_item(AGENT_IDX_W'($urandom), random_pos());
        item.mode = MODE_TICK;
        return item;
    endfunction

    // Hold valid until the transfer, then idle or keep valid up for the next item.
    task automatic send_item(input t_in_item item);
        int gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        sent_count++;
        if (item.mode == MODE_TICK)
            tick_count++;
        gap = draw_gap(tx_quiet);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain all expected entries, then let the block idle before the next phase.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [COUNT_W-1:0] count,
                              input logic [RADIUS_W-1:0] radius);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_AGENT_COUNT;
        cfg_data <= CFG_DATA_W'(count);
        @(posedge i_clk);
        cfg_idx  <= REG_NEIGHBOR_RADIUS;
        cfg_data <= CFG_DATA_W'(radius);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        setting_count++;
    endtask

    // Rounds of shuffled reports followed by a tick, with early ticks, stray
    // updates, repeated positions and skipped reports mixed in.
    task automatic random_phase(input logic [COUNT_W-1:0] count,
                                input logic [RADIUS_W-1:0] radius,
                                input int spread, input bit full_range,
                                input bit squeeze, input int quota);
        int   n, start, skip, k, j, tmp;
        int   order [MAX_AGENTS];
        t_pos center, p, prev;
        settle();
        write_regs(count, radius);
        if (squeeze)
            pressure_go = 1'b1;
        n = (count > MAX_AGENTS) ? MAX_AGENTS : int'(count);
        center = random_pos();
        prev = center;
        start = sent_count;
        while (sent_count - start < quota) begin
            for (k = 0; k < n; k++)
                order[k] = k;
            for (k = n - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
            for (k = 0; k < n; k++) begin
                if (order[k] == skip)
                    continue;
                case ($urandom_range(0, 11))
                    0: send_item(tick_item());
                    1: if (n < MAX_AGENTS)
                        send_item(update_item(AGENT_IDX_W'($urandom_range(n, MAX_AGENTS - 1)),
                                              random_pos()));
                    default: ;
                endcase
                if ($urandom_range(0, 7) == 0)
                    p = prev;
                else if (full_range)
                    p = random_pos();
                else
                    p = near_pos(center, spread);
                send_item(update_item(AGENT_IDX_W'(order[k]), p));
                prev = p;
            end
            send_item(tick_item());
        end
    endtask

    initial begin
        t_pos lo, hi, p;
        int   a, spread;
        lo = {3{24'h800000}};
        hi = {3{24'h7FFFFF}};
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: early tick is ignored, zero radius gives no pairs.
        send_item(tick_item());
        for (a = 0; a < MAX_AGENTS; a++) begin
            p.x = COORD_W'(a * 256);
            p.y = COORD_W'(-a * 256);
            p.z = COORD_W'(a);
            send_item(update_item(AGENT_IDX_W'(a), p));
        end
        send_item(tick_item());

        // Count above the maximum, largest radius, extreme and coincident positions.
        settle();
        write_regs(4'hF, 24'hFFFFFF);
        send_item(update_item(AGENT_IDX_W'(0), lo));
        send_item(update_item(AGENT_IDX_W'(1), hi));
        send_item(update_item(AGENT_IDX_W'(2), lo));
        for (a = 3; a < MAX_AGENTS; a++)
            send_item(update_item(AGENT_IDX_W'(a), random_pos()));
        send_item(tick_item());
        send_item(tick_item());

        // No active agents, then a single agent with an update outside the set.
        settle();
        write_regs(4'd0, 24'd1000);
        send_item(tick_item());
        settle();
        write_regs(4'd1, 24'd1000);
        send_item(update_item(AGENT_IDX_W'(3), random_pos()));
        send_item(tick_item());

        // Two agents exactly one radius apart.
        settle();
        write_regs(4'd2, 24'd5);
        send_item(update_item(AGENT_IDX_W'(0), '0));
        p = '0;
        p.x = 24'sd3;
        p.y = 24'sd4;
        send_item(update_item(AGENT_IDX_W'(1), p));
        send_item(tick_item());

        spread = 1 << $urandom_range(4, 12);
        random_phase(4'd8, RADIUS_W'(spread * $urandom_range(1, 3)), spread, 1'b0, 1'b0, 32);
        random_phase(4'd2, 24'hFFFFFF, 0, 1'b1, 1'b0, 22);
        spread = 1 << $urandom_range(14, 20);
        random_phase(4'd12, RADIUS_W'(spread * 2), spread, 1'b0, 1'b0, 32);
        spread = 1 << $urandom_range(2, 16);
        random_phase(COUNT_W'($urandom_range(3, 7)), RADIUS_W'($urandom_range(0, 3 * spread)),
                     spread, 1'b0, 1'b0, 32);
        random_phase(4'd8, RADIUS_W'(3 * 1024), 1024, 1'b0, 1'b1, 32);
        spread = 1 << $urandom_range(2, 20);
        random_phase(COUNT_W'($urandom_range(2, 8)), RADIUS_W'(spread), spread, 1'b0, 1'b0, 32);
        settle();

        $display("Covered %0d input transfers (%0d ticks) over %0d register settings,",
                 sent_count, tick_count, setting_count);
        $display("%0d neighbor entries compared, one %0d-cycle output hold-off.",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/frns_pkg.sv
rtl/core/frns_pos_ram.sv
rtl/core/frns_dist_pipe.sv
rtl/core/frns_out_stage.sv
rtl/core/fixed_radius_neighbor_search.sv
rtl/core/frns_checker.sv
tb/frns_checker.sv
tb/tb_top.sv
